// ----- design/u8u16_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 (BMP) decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [15:0] MAX_UNITS_RESET = 16'hFFFF;

  // byte classes seen by the back end
  typedef enum logic [2:0] {
    KIND_END   = 3'd0,  // zero byte
    KIND_ASCII = 3'd1,  // 0xxxxxxx
    KIND_CONT  = 3'd2,  // 10xxxxxx
    KIND_LEAD2 = 3'd3,  // 110xxxxx
    KIND_LEAD3 = 3'd4,  // 1110xxxx
    KIND_OTHER = 3'd5   // four-byte lead and 0xF8..0xFF
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] bits;   // payload bits of the byte, right aligned
  } cls_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_end;
    logic [15:0] unit_count;
  } res_t;

endpackage
`default_nettype wire

// ----- design/u8u16_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_queue
// Small synchronous FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module u8u16_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             rd,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/u8u16_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts input bytes and classifies them by their UTF-8 role.
// ----------------------------------------------------------------------------
module u8u16_front (
  input  wire logic          push,
  input  wire logic [7:0]    in_byte,
  output logic               full,
  input  wire logic          q_full,
  output logic               q_wr,
  output u8u16_pkg::cls_t    q_data
);

  assign full = q_full;
  assign q_wr = push && !q_full;

  always_comb begin
    q_data.bits = in_byte[6:0];
    if (in_byte == 8'h00) begin
      q_data.kind = u8u16_pkg::KIND_END;
    end else if (in_byte inside {[8'h01:8'h7F]}) begin
      q_data.kind = u8u16_pkg::KIND_ASCII;
    end else if (in_byte inside {[8'h80:8'hBF]}) begin
      q_data.kind = u8u16_pkg::KIND_CONT;
    end else if (in_byte inside {[8'hC0:8'hDF]}) begin
      q_data.kind = u8u16_pkg::KIND_LEAD2;
    end else if (in_byte inside {[8'hE0:8'hEF]}) begin
      q_data.kind = u8u16_pkg::KIND_LEAD3;
    end else begin
      q_data.kind = u8u16_pkg::KIND_OTHER;
    end
  end

endmodule
`default_nettype wire

// ----- design/u8u16_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_back
// Sequence assembly: pending count, partial code and unit count; one
// classified word per cycle while res_full is low.
// ----------------------------------------------------------------------------
module u8u16_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [15:0]     limit,
  input  wire logic            cls_valid,
  input  wire u8u16_pkg::cls_t cls,
  output logic                 cls_take,
  input  wire logic            res_full,
  output logic                 res_wr,
  output u8u16_pkg::res_t      res
);

  logic [1:0]  pending;
  logic [15:0] partial;
  logic [15:0] emitted;
  logic [1:0]  pending_next;
  logic [15:0] partial_next;
  logic [15:0] emitted_next;
  logic [1:0]  pend_dec;
  logic [15:0] cont_bits;
  logic        emit;

  assign cls_take = cls_valid && !res_full;
  assign pend_dec = pending - 2'd1;
  // second-to-last byte lands at bit 6, last byte at bit 0
  assign cont_bits = (pend_dec == 2'd1) ? {4'd0, cls.bits[5:0], 6'd0}
                                        : {10'd0, cls.bits[5:0]};

  always_comb begin
    pending_next   = pending;
    partial_next   = partial;
    emitted_next   = emitted;
    emit           = 1'b0;
    res.code_unit  = 16'd0;
    res.is_end     = 1'b0;
    res.unit_count = 16'd0;
    if (cls.kind == u8u16_pkg::KIND_END) begin
      emit           = 1'b1;
      res.is_end     = 1'b1;
      res.unit_count = emitted;
      pending_next   = 2'd0;
      partial_next   = 16'd0;
      emitted_next   = 16'd0;
    end else if (pending != 2'd0) begin
      if (cls.kind != u8u16_pkg::KIND_CONT) begin
        // bad continuation: drop the sequence and the byte
        pending_next = 2'd0;
        partial_next = 16'd0;
      end else if (pend_dec == 2'd0) begin
        emit          = 1'b1;
        res.code_unit = partial | cont_bits;
        pending_next  = 2'd0;
        partial_next  = 16'd0;
        emitted_next  = emitted + 16'd1;
      end else begin
        pending_next = pend_dec;
        partial_next = partial | cont_bits;
      end
    end else if (emitted < limit) begin
      case (cls.kind)
        u8u16_pkg::KIND_ASCII: begin
          emit          = 1'b1;
          res.code_unit = {9'd0, cls.bits};
          emitted_next  = emitted + 16'd1;
        end
        u8u16_pkg::KIND_LEAD2: begin
          pending_next = 2'd1;
          partial_next = {5'd0, cls.bits[4:0], 6'd0};
        end
        u8u16_pkg::KIND_LEAD3: begin
          pending_next = 2'd2;
          partial_next = {cls.bits[3:0], 12'd0};
        end
        default: begin
        end
      endcase
    end
  end

  assign res_wr = cls_take && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      partial <= 16'd0;
      emitted <= 16'd0;
    end else if (cls_take) begin
      pending <= pending_next;
      partial <= partial_next;
      emitted <= emitted_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/utf8_to_utf16_bmp_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_bmp_decoder
// Zero-terminated UTF-8 byte stream in, 16-bit BMP code units out.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while not full; delivers at most one word per
// cycle. A byte classifier feeds a short queue; the assembly stage drains
// it into an output queue one word per cycle while that queue has room, so
// a stalled reader does not block input until both queues fill. Bytes are
// registered in the class queue, results in the output queue. Bytes with no
// result still pass through. Write max_units only while the block is idle.
// ----------------------------------------------------------------------------
module utf8_to_utf16_bmp_decoder #(
  parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr,
  input  wire logic [15:0] cfg_data,
  input  wire logic        push,
  input  wire logic [7:0]  in_byte,
  output logic             full,
  input  wire logic        pop,
  output logic             empty,
  output logic [15:0]      code_unit,
  output logic             is_end,
  output logic [15:0]      unit_count
);

  localparam int unsigned CLS_W = $bits(u8u16_pkg::cls_t);
  localparam int unsigned RES_W = $bits(u8u16_pkg::res_t);

  logic [15:0]      limit;
  logic             cq_full;
  logic             cq_wr;
  u8u16_pkg::cls_t  cq_wdata;
  logic [CLS_W-1:0] cq_rdata;
  logic             cq_empty;
  logic             cq_rd;
  logic             rq_full;
  logic             rq_wr;
  u8u16_pkg::res_t  rq_wdata;
  logic [RES_W-1:0] rq_rdata;
  u8u16_pkg::res_t  head;

  // stored as max_units - 1; zero max_units means no units
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= u8u16_pkg::MAX_UNITS_RESET - 16'd1;
    end else if (cfg_wr) begin
      limit <= (cfg_data == 16'd0) ? 16'd0 : cfg_data - 16'd1;
    end
  end

  u8u16_front u_front (
    .push    (push),
    .in_byte (in_byte),
    .full    (full),
    .q_full  (cq_full),
    .q_wr    (cq_wr),
    .q_data  (cq_wdata)
  );

  u8u16_queue #(
    .WIDTH (CLS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cls_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (cq_wr),
    .wdata (cq_wdata),
    .full  (cq_full),
    .rd    (cq_rd),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .limit     (limit),
    .cls_valid (!cq_empty),
    .cls       (u8u16_pkg::cls_t'(cq_rdata)),
    .cls_take  (cq_rd),
    .res_full  (rq_full),
    .res_wr    (rq_wr),
    .res       (rq_wdata)
  );

  u8u16_queue #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (rq_wr),
    .wdata (rq_wdata),
    .full  (rq_full),
    .rd    (pop),
    .rdata (rq_rdata),
    .empty (empty)
  );

  assign head       = u8u16_pkg::res_t'(rq_rdata);
  assign code_unit  = head.code_unit;
  assign is_end     = head.is_end;
  assign unit_count = head.unit_count;

endmodule
`default_nettype wire

// ----- design/u8u16_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8u16_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pop,
  input wire logic        empty,
  input wire logic [15:0] code_unit,
  input wire logic        is_end,
  input wire logic [15:0] unit_count
);

  // nothing is left waiting after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // terminator word carries a zero code unit
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_end) |-> (code_unit == 16'd0))
    else $error("terminator with nonzero code unit");

  // count is only reported on the terminator
  a_count_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !is_end) |-> (unit_count == 16'd0))
    else $error("unit count on a non-terminator word");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(code_unit) && $stable(is_end)
                          && $stable(unit_count)))
    else $error("stalled output word changed");

endmodule

bind utf8_to_utf16_bmp_decoder u8u16_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .pop        (pop),
  .empty      (empty),
  .code_unit  (code_unit),
  .is_end     (is_end),
  .unit_count (unit_count)
);
`default_nettype wire
